### rtl/qgi_pkg.sv
// Shared types, constants and tables for the quaternion gyro integrator.
// Used by qgi_ctrl, qgi_datapath, qgi_div and quaternion_gyro_integrator.
package qgi_pkg;

    // CORDIC length, clamped to the range the angle table covers
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 :
                                  ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERS - 1);

    // Fixed-point constants
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;   // Q2.30
    localparam logic signed [33:0] TWO_OVER_PI = 34'sd10680707;    // Q0.24
    localparam logic signed [33:0] HALF_PI     = 34'sd1686629713;  // Q2.30
    localparam logic signed [31:0] ONE_Q29     = 32'sd536870912;
    localparam logic [31:0]        TIME_STEP_RESET  = 32'd4294967;
    localparam logic [15:0]        RATE_FLOOR_RESET = 16'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR = 2'd1;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE  = 5'd0,
        OP_START = 5'd1,
        OP_LOAD  = 5'd2,
        OP_SQ    = 5'd3,
        OP_SQRT  = 5'd4,
        OP_MULDT = 5'd5,
        OP_MULU  = 5'd6,
        OP_MULZ  = 5'd7,
        OP_CINIT = 5'd8,
        OP_CORD  = 5'd9,
        OP_MAP   = 5'd10,
        OP_PRD   = 5'd11,
        OP_DINIT = 5'd12,
        OP_DIV   = 5'd13,
        OP_MAC   = 5'd14,
        OP_RND   = 5'd15,
        OP_OUT   = 5'd16
    } qgi_op_t;

    typedef struct packed {
        qgi_op_t    op;
        logic [4:0] cnt;
    } qgi_cmd_t;

    typedef struct packed {
        logic small_rate;
    } qgi_stat_t;

    // Rounded atan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Hamilton product signs: term t of component c uses q[t] * d[t ^ c]
    function automatic logic hamilton_neg(input logic [1:0] comp, input logic [1:0] term);
        logic n;
        unique case ({comp, term})
            4'b0001, 4'b0010, 4'b0011: n = 1'b1;
            4'b0111:                   n = 1'b1;
            4'b1001:                   n = 1'b1;
            4'b1110:                   n = 1'b1;
            default:                   n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

### rtl/qgi_div.sv
// Restoring divider lane, one quotient bit per cycle while step is high, 32-bit quotient.
// Needs num[63:32] < den. Depends on qgi_pkg.
module qgi_div
    import qgi_pkg::*;
(
    input  logic        clk,
    input  logic        start,
    input  logic        step,
    input  logic [63:0] num,
    input  logic [32:0] den,
    output logic [31:0] quo
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] lo_reg, lo_next;
    logic [33:0] trial;

    // load on start, else one shift-subtract step while step is high; quotient bits fill lo from the bottom
    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        trial    = {rem_reg, lo_reg[31]};
        if (start)
        begin
            rem_next = {1'b0, num[63:32]};
            lo_next  = num[31:0];
        end
        else if (step)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = 33'(trial - {1'b0, den});
                lo_next  = {lo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                lo_next  = {lo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
    end

    assign quo = lo_reg;

endmodule

### rtl/qgi_ctrl.sv
// Controller FSM: sequences square, root, angle, CORDIC, division, product, load and output steps.
// Depends on qgi_pkg.
module qgi_ctrl
    import qgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      action,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  qgi_stat_t stat,
    output qgi_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SQ    = 15'b000000000000010,
        S_SQRT  = 15'b000000000000100,
        S_CHK   = 15'b000000000001000,
        S_MULU  = 15'b000000000010000,
        S_MULZ  = 15'b000000000100000,
        S_CINIT = 15'b000000001000000,
        S_CORD  = 15'b000000010000000,
        S_MAP   = 15'b000000100000000,
        S_PRD   = 15'b000001000000000,
        S_DINIT = 15'b000010000000000,
        S_DIV   = 15'b000100000000000,
        S_MAC   = 15'b001000000000000,
        S_RND   = 15'b010000000000000,
        S_FIN   = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        cmd.cnt        = cnt_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (action)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_START;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.op     = OP_MULDT;
                state_next = stat.small_rate ? S_FIN : S_MULU;
            end
            S_MULU:
            begin
                cmd.op     = OP_MULU;
                state_next = S_MULZ;
            end
            S_MULZ:
            begin
                cmd.op     = OP_MULZ;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.op     = OP_CINIT;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op   = OP_CORD;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.op     = OP_MAP;
                cnt_next   = '0;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.op   = OP_PRD;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                    state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.op   = OP_MAC;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                    state_next = S_RND;
            end
            S_RND:
            begin
                cmd.op     = OP_RND;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/qgi_datapath.sv
// Datapath: config and attitude registers, shared multiplier, root, CORDIC,
// three divider lanes and the Hamilton product. Depends on qgi_pkg, qgi_div.
module qgi_datapath
    import qgi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qgi_cmd_t             cmd,
    output qgi_stat_t            stat,
    input  logic signed [31:0]   rate_x,
    input  logic signed [31:0]   rate_y,
    input  logic signed [31:0]   rate_z,
    input  logic signed [31:0]   load_w,
    input  logic signed [31:0]   load_x,
    input  logic signed [31:0]   load_y,
    input  logic signed [31:0]   load_z,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic signed [31:0]   att_w,
    output logic signed [31:0]   att_x,
    output logic signed [31:0]   att_y,
    output logic signed [31:0]   att_z
);

    logic [31:0]        time_step_reg;
    logic [15:0]        rate_floor_reg;
    logic signed [31:0] att_reg [4];
    logic signed [31:0] out_reg [4];
    logic signed [31:0] rate_reg [3];

    logic signed [39:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [73:0] prod_reg;

    logic [63:0]        sum_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] s_reg;
    logic signed [30:0] d0_reg;
    logic [63:0]        num_reg [3];
    logic               neg_reg [3];
    logic signed [63:0] acc_reg [4];
    logic [1:0]         mac_comp_reg;
    logic               mac_neg_reg;

    logic signed [31:0] rate_sel;
    logic signed [31:0] q_sel;
    logic signed [30:0] d_sel;
    logic signed [30:0] d_lane [3];
    logic [31:0]        quo [3];
    logic [1:0]         term, comp, didx;
    logic [35:0]        rem_sh, trial;
    logic signed [33:0] xs, ys, atan_v;
    logic signed [33:0] c_map, s_map, c_half;
    logic signed [63:0] prod64;

    assign stat.small_rate = (root_reg == 32'd0) || (root_reg < {16'd0, rate_floor_reg});

    assign term   = cmd.cnt[1:0];
    assign comp   = cmd.cnt[3:2];
    assign didx   = term ^ comp;
    assign prod64 = prod_reg[63:0];

    // round half up by 29 bits and saturate to 32 bits
    function automatic logic signed [31:0] sat_round(input logic signed [63:0] a);
        logic signed [63:0] t;
        t = (a + 64'sd268435456) >>> 29;
        if (t > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (t < -64'sd2147483648)
            return 32'sh80000000;
        else
            return t[31:0];
    endfunction

    // operand selects
    always_comb
    begin
        unique case (cmd.cnt[1:0])
            2'd0:    rate_sel = rate_reg[0];
            2'd1:    rate_sel = rate_reg[1];
            2'd2:    rate_sel = rate_reg[2];
            default: rate_sel = '0;
        endcase
        q_sel = att_reg[term];
        unique case (didx)
            2'd0:    d_sel = d0_reg;
            2'd1:    d_sel = d_lane[0];
            2'd2:    d_sel = d_lane[1];
            default: d_sel = d_lane[2];
        endcase
    end

    // divider lanes: clamp quotient to one and apply the sign of the product
    for (genvar k = 0; k < 3; k++)
    begin : g_div
        logic [31:0] qmin;
        qgi_div u_div (
            .clk   (clk),
            .start (cmd.op == OP_DINIT),
            .step  (cmd.op == OP_DIV),
            .num   (num_reg[k]),
            .den   ({root_reg, 1'b0}),
            .quo   (quo[k])
        );
        assign qmin      = (quo[k] > 32'(ONE_Q29)) ? 32'(ONE_Q29) : quo[k];
        assign d_lane[k] = neg_reg[k] ? -$signed({1'b0, qmin[29:0]})
                                      : $signed({1'b0, qmin[29:0]});
    end

    // shared multiplier inputs
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQ:
            begin
                mul_a = 40'(rate_sel);
                mul_b = 34'(rate_sel);
            end
            OP_MULDT:
            begin
                mul_a = {8'd0, root_reg};
                mul_b = {2'd0, time_step_reg};
            end
            OP_MULU:
            begin
                mul_a = {1'b0, prod_reg[63:25]};
                mul_b = TWO_OVER_PI;
            end
            OP_MULZ:
            begin
                mul_a = {8'd0, prod_reg[55:24]};
                mul_b = HALF_PI;
            end
            OP_PRD:
            begin
                mul_a = 40'(rate_sel);
                mul_b = s_reg;
            end
            OP_MAC:
            begin
                mul_a = 40'(q_sel);
                mul_b = 34'(d_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // root step, CORDIC step and quadrant map terms
    always_comb
    begin
        rem_sh = {rem_reg[33:0], sum_reg[63:62]};
        trial  = {2'd0, root_reg, 2'b01};
        xs     = x_reg >>> cmd.cnt;
        ys     = y_reg >>> cmd.cnt;
        atan_v = $signed({4'd0, atan_q30(cmd.cnt)});
        unique case (quad_reg)
            2'd0:
            begin
                c_map = x_reg;
                s_map = y_reg;
            end
            2'd1:
            begin
                c_map = -y_reg;
                s_map = x_reg;
            end
            2'd2:
            begin
                c_map = -x_reg;
                s_map = -y_reg;
            end
            default:
            begin
                c_map = y_reg;
                s_map = -x_reg;
            end
        endcase
        c_half = c_map >>> 1;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // configuration and attitude registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RESET;
            rate_floor_reg <= RATE_FLOOR_RESET;
            att_reg[0]     <= ONE_Q29;
            att_reg[1]     <= '0;
            att_reg[2]     <= '0;
            att_reg[3]     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TIME_STEP)
                time_step_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_RATE_FLOOR)
                rate_floor_reg <= cfg_data[15:0];
            if (cmd.op == OP_LOAD)
            begin
                att_reg[0] <= load_w;
                att_reg[1] <= load_x;
                att_reg[2] <= load_y;
                att_reg[3] <= load_z;
            end
            else if (cmd.op == OP_RND)
            begin
                for (int i = 0; i < 4; i++)
                    att_reg[i] <= sat_round(acc_reg[i]);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_START:
            begin
                rate_reg[0] <= rate_x;
                rate_reg[1] <= rate_y;
                rate_reg[2] <= rate_z;
                sum_reg     <= '0;
                rem_reg     <= '0;
                root_reg    <= '0;
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= '0;
            end
            OP_SQ:
            begin
                if (cmd.cnt != 5'd0)
                    sum_reg <= sum_reg + prod64;
            end
            OP_SQRT:
            begin
                sum_reg <= {sum_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_MULZ:
            begin
                quad_reg <= prod_reg[57:56];
            end
            OP_CINIT:
            begin
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                z_reg <= $signed({3'd0, prod_reg[62:32]});
            end
            OP_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_MAP:
            begin
                s_reg <= s_map;
                if (c_half > 34'(ONE_Q29))
                    d0_reg <= 31'(ONE_Q29);
                else if (c_half < -34'(ONE_Q29))
                    d0_reg <= -31'(ONE_Q29);
                else
                    d0_reg <= c_half[30:0];
            end
            OP_PRD:
            begin
                unique case (cmd.cnt[1:0])
                    2'd1:
                    begin
                        num_reg[0] <= prod64[63] ? 64'(-prod64) : prod64;
                        neg_reg[0] <= prod64[63];
                    end
                    2'd2:
                    begin
                        num_reg[1] <= prod64[63] ? 64'(-prod64) : prod64;
                        neg_reg[1] <= prod64[63];
                    end
                    2'd3:
                    begin
                        num_reg[2] <= prod64[63] ? 64'(-prod64) : prod64;
                        neg_reg[2] <= prod64[63];
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_MAC:
            begin
                if (!cmd.cnt[4])
                begin
                    mac_comp_reg <= comp;
                    mac_neg_reg  <= hamilton_neg(comp, term);
                end
                if (cmd.cnt != 5'd0)
                    acc_reg[mac_comp_reg] <= mac_neg_reg ? acc_reg[mac_comp_reg] - prod64
                                                         : acc_reg[mac_comp_reg] + prod64;
            end
            OP_OUT:
            begin
                for (int i = 0; i < 4; i++)
                    out_reg[i] <= att_reg[i];
            end
            default:
            begin
            end
        endcase
    end

    assign att_w = out_reg[0];
    assign att_x = out_reg[1];
    assign att_y = out_reg[2];
    assign att_z = out_reg[3];

endmodule

### rtl/quaternion_gyro_integrator.sv
// Quaternion gyro integrator, top level: controller plus datapath.
// Attitude q <- q * dq with dq from the body rates and time step.
// Depends on qgi_pkg, qgi_ctrl, qgi_datapath.
//
// Usage:
//   Input channel in_valid/in_ready carries one item per transfer: action 0
//   integrates rate_x/y/z, action 1 loads load_w/x/y/z as the attitude.
//   Output channel out_valid/out_ready carries the attitude after each item.
//   Config: cfg_we writes cfg_data to register cfg_index (0 time_step,
//   1 rate_floor) in the same cycle; other indexes are ignored.
// Sequence:
//   One item at a time. An integrate item runs the rate squares, the
//   bit-pair square root, the angle multiplies, the CORDIC loop, the
//   divider lanes, 16 product terms through the single shared multiplier
//   and the final rounding, in that order. A rate below the floor finishes
//   after the root; a load goes straight to the output.
//   The result sits in an output register; the block takes the next item
//   while it waits and only holds its last step while the receiver stalls.
// Reset: attitude is the identity, config registers take their defaults.
module quaternion_gyro_integrator
    import qgi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic signed [31:0]   rate_x,
    input  logic signed [31:0]   rate_y,
    input  logic signed [31:0]   rate_z,
    input  logic signed [31:0]   load_w,
    input  logic signed [31:0]   load_x,
    input  logic signed [31:0]   load_y,
    input  logic signed [31:0]   load_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   att_w,
    output logic signed [31:0]   att_x,
    output logic signed [31:0]   att_y,
    output logic signed [31:0]   att_z,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    qgi_cmd_t  cmd;
    qgi_stat_t stat;

    qgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    qgi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .load_w    (load_w),
        .load_x    (load_x),
        .load_y    (load_y),
        .load_z    (load_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .att_w     (att_w),
        .att_x     (att_x),
        .att_y     (att_y),
        .att_z     (att_z)
    );

endmodule
